FILE: hdl/mass_pkg.sv
// Shared types, constants and helpers for the markup attribute span scanner.
package mass_pkg;

  localparam int MaxScanChars = 65536;
  localparam int IdxW         = $clog2(MaxScanChars);
  localparam int PosW         = 31;
  localparam int CharW        = 8;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChEqual = 8'h3D;
  localparam logic [CharW-1:0] ChQuote = 8'h22;

  typedef enum logic [2:0] {
    ST_INVALID = 3'd0,
    ST_KEY     = 3'd1,
    ST_PRE     = 3'd2,
    ST_ASSIGN  = 3'd3,
    ST_STRING  = 3'd4,
    ST_VALUE   = 3'd5,
    ST_VALID   = 3'd6
  } scan_state_e;

  typedef enum logic [1:0] {
    CC_SPACE,
    CC_EQUAL,
    CC_QUOTE,
    CC_OTHER
  } char_class_e;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] span_start;
    logic [PosW-1:0] span_end;
    logic            done;
  } result_t;

  function automatic char_class_e classify(input logic [CharW-1:0] c);
    char_class_e cls;
    if (c == ChSpace || c == ChTab || c == ChLf || c == ChCr) begin
      cls = CC_SPACE;
    end else if (c == ChEqual) begin
      cls = CC_EQUAL;
    end else if (c == ChQuote) begin
      cls = CC_QUOTE;
    end else begin
      cls = CC_OTHER;
    end
    return cls;
  endfunction

endpackage

FILE: hdl/mass_core.sv
// Scan state machine, character index and span position logic.
module mass_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [mass_pkg::CharW-1:0]    char_code_i,
  input  logic                          last_char_i,
  input  logic [mass_pkg::PosW-1:0]     base_i,
  output mass_pkg::result_t             result_o
);
  import mass_pkg::*;

  localparam logic [IdxW-1:0] IdxMax = IdxW'(MaxScanChars - 1);

  scan_state_e     state_q, state_d;
  scan_state_e     trans, settled;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] ks_q, ks_d;
  char_class_e     cls;
  logic            ks_load;
  logic            ws_close;
  logic            closes;
  logic            open_close;
  logic            found;

  assign cls = classify(char_code_i);

  // transition, then resolve a completed attribute back to invalid
  always_comb begin
    trans    = state_q;
    ks_load  = 1'b0;
    ws_close = 1'b0;
    case (cls)
      CC_SPACE: begin
        case (state_q)
          ST_KEY:   trans = ST_PRE;
          ST_VALUE: begin
            trans    = ST_VALID;
            ws_close = 1'b1;
          end
          default: ;
        endcase
      end
      CC_EQUAL: begin
        case (state_q)
          ST_KEY, ST_PRE:      trans = ST_ASSIGN;
          ST_ASSIGN, ST_VALUE: trans = ST_INVALID;
          default: ;
        endcase
      end
      CC_QUOTE: begin
        case (state_q)
          ST_STRING:                trans = ST_VALID;
          ST_KEY, ST_PRE, ST_VALUE: trans = ST_INVALID;
          ST_ASSIGN:                trans = ST_STRING;
          default: ;
        endcase
      end
      default: begin
        case (state_q)
          ST_INVALID: begin
            trans   = ST_KEY;
            ks_load = 1'b1;
          end
          ST_PRE:    trans = ST_INVALID;
          ST_ASSIGN: trans = ST_VALUE;
          default: ;
        endcase
      end
    endcase

    closes  = (trans >= ST_VALID);
    settled = closes ? ST_INVALID : trans;

    if (last_char_i) begin
      state_d = ST_INVALID;
      idx_d   = '0;
      ks_d    = '0;
    end else begin
      state_d = settled;
      idx_d   = (idx_q == IdxMax) ? idx_q : idx_q + 1'b1;
      ks_d    = ks_load ? idx_q : ks_q;
    end
  end

  // span outputs; an open bare value is closed by the last character
  always_comb begin
    open_close          = last_char_i && (settled == ST_VALUE);
    found               = closes || open_close;
    result_o.found      = found;
    result_o.done       = last_char_i;
    result_o.span_start = found ? base_i + PosW'(ks_q) : '0;
    result_o.span_end   = found ? base_i + PosW'(idx_q) + PosW'(closes && !ws_close) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INVALID;
      idx_q   <= '0;
      ks_q    <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ks_q    <= ks_d;
    end
  end

  a_no_held_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q < ST_VALID)
    else $error("completed state held in scan register");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxMax && ks_q <= idx_q)
    else $error("character index out of range");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_char_i |=> state_q == ST_INVALID && idx_q == '0 && ks_q == '0)
    else $error("scan state not cleared after last character");

endmodule

FILE: hdl/markup_attribute_span_scanner_top.sv
// Top level of the markup attribute span scanner: handshakes, word registers, base register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word per tag-interior
//   character: char_code_i and last_char_i, which marks the final character.
//   Output channel (out_valid_o / out_ready_i) returns exactly one word per
//   input word: span_found_o, span_start_o, span_end_o and scan_done_o.
//   Config channel (cfg_valid_i / cfg_ready_o, cfg_data_i) sets the 31-bit
//   base position added to all span positions; cfg_ready_o is always high.
//   Write it only while no words are in flight.
// Path: an accepted word passes the input register, then the result register that drives the outputs.
// Throughput: one word per cycle while out_ready_i is high, bounded by the state step
//   between the input register and the result register.
// Reset: scan state, index and base return to zero; both word registers empty.
// Receiver stall: the result register holds; the input register still takes
//   one more word, then in_ready_o drops until the result is taken.
module markup_attribute_span_scanner_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mass_pkg::PosW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mass_pkg::CharW-1:0]    char_code_i,
  input  logic                          last_char_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          span_found_o,
  output logic [mass_pkg::PosW-1:0]     span_start_o,
  output logic [mass_pkg::PosW-1:0]     span_end_o,
  output logic                          scan_done_o
);
  import mass_pkg::*;

  logic             base_en;
  logic [PosW-1:0]  base_q;
  logic             in_vld_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             out_vld_q;
  result_t          res_d, res_q;
  logic             advance;
  logic             in_take;

  // config register, always ready
  assign cfg_ready_o = 1'b1;
  assign base_en     = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (base_en) begin
      base_q <= cfg_data_i;
    end
  end

  // move the buffered word on when the result register is free or draining
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  mass_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .char_code_i (char_q),
    .last_char_i (last_q),
    .base_i      (base_q),
    .result_o    (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign span_found_o = res_q.found;
  assign span_start_o = res_q.span_start;
  assign span_end_o   = res_q.span_end;
  assign scan_done_o  = res_q.done;

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i && in_vld_q |-> !in_ready_o)
    else $error("input accepted while both word registers are full");

  a_zero_when_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !span_found_o |-> span_start_o == '0 && span_end_o == '0)
    else $error("span positions non-zero without a span");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q && res_q.done == $past(last_q))
    else $error("result register not loaded from buffered word");

endmodule
